[rtl/ttb_pkg.sv]
// Shared widths, constants and the triangle record type of the tangent/binormal block.
package ttb_pkg;

   localparam int PosW      = 24;
   localparam int UvW       = 16;
   localparam int OutW      = 48;
   localparam int PdW       = PosW + 1;
   localparam int UdW       = UvW + 1;
   localparam int DenW      = 2 * UdW + 1;
   localparam int NumW      = PdW + UdW + 1;
   localparam int FracShift = 30;
   localparam int QuotW     = OutW;
   localparam int IntBits   = QuotW - FracShift;
   localparam int RemW      = DenW + 1;
   localparam int StepsPerCycle = 2;
   localparam int Lanes     = 6;
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic signed [PdW-1:0] p10_x;
      logic signed [PdW-1:0] p10_y;
      logic signed [PdW-1:0] p10_z;
      logic signed [PdW-1:0] p20_x;
      logic signed [PdW-1:0] p20_y;
      logic signed [PdW-1:0] p20_z;
      logic signed [UdW-1:0] u10;
      logic signed [UdW-1:0] v10;
      logic signed [UdW-1:0] u20;
      logic signed [UdW-1:0] v20;
   } ttb_tri_type;

endpackage

[rtl/triangle_tangent_binormal.sv]
// Top level of the per-triangle tangent and binormal unit.
//
// Corners enter one beat at a time on the req_ channel (push/full): position
// in integer units and UV in signed Q2.14. Every third beat closes a
// triangle; the first two beats never stall and produce nothing. The third
// beat stalls only while the internal record queue is full.
// Each triangle yields one beat on the rsp_ channel (empty/pop): tangent and
// binormal in signed Q18.30, a degenerate-UV flag and a saturation flag.
// The back end works on one triangle at a time: a multiply step, then six
// restoring-division lanes that retire two quotient bits per cycle over
// 48 bits, plus setup and finish steps. A degenerate triangle skips the
// division.
// The result register frees when the receiver pops it; while it is held the
// back end finishes its current triangle and waits, and the queue and the
// corner capture keep taking beats until the queue fills.
// Synchronous reset empties the queue and result register and restarts the
// corner count; held corner data is not cleared.
module triangle_tangent_binormal #(
   parameter int QUEUE_DEPTH = ttb_pkg::QueueDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_x,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_y,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_z,
   input  logic signed [ttb_pkg::UvW-1:0]  req_tex_u,
   input  logic signed [ttb_pkg::UvW-1:0]  req_tex_v,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_x,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_y,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_z,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_x,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_y,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_z,
   output logic                            rsp_degenerate_uv,
   output logic                            rsp_saturated
);

   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   ttb_pkg::ttb_tri_type q_wdata;
   ttb_pkg::ttb_tri_type q_rdata;

   ttb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_tex_u   (req_tex_u),
      .req_tex_v   (req_tex_v),
      .q_push      (q_push),
      .q_full      (q_full),
      .q_data      (q_wdata)
   );

   ttb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .data_out (q_rdata),
      .empty    (q_empty)
   );

   ttb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_data            (q_rdata),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_tangent_x     (rsp_tangent_x),
      .rsp_tangent_y     (rsp_tangent_y),
      .rsp_tangent_z     (rsp_tangent_z),
      .rsp_binormal_x    (rsp_binormal_x),
      .rsp_binormal_y    (rsp_binormal_y),
      .rsp_binormal_z    (rsp_binormal_z),
      .rsp_degenerate_uv (rsp_degenerate_uv),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

[rtl/ttb_front.sv]
// Corner capture: holds the first two corners and forms the edge and UV deltas on the third.
module ttb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_x,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_y,
   input  logic signed [ttb_pkg::PosW-1:0] req_point_z,
   input  logic signed [ttb_pkg::UvW-1:0]  req_tex_u,
   input  logic signed [ttb_pkg::UvW-1:0]  req_tex_v,
   output logic                          q_push,
   input  logic                          q_full,
   output ttb_pkg::ttb_tri_type          q_data
);

   localparam logic [1:0] LastCorner = 2'd2;

   logic [1:0] corner_count_ff;
   logic [1:0] corner_count_in;
   logic       accept;

   logic signed [ttb_pkg::PosW-1:0] held_x_ff [2];
   logic signed [ttb_pkg::PosW-1:0] held_y_ff [2];
   logic signed [ttb_pkg::PosW-1:0] held_z_ff [2];
   logic signed [ttb_pkg::UvW-1:0]  held_u_ff [2];
   logic signed [ttb_pkg::UvW-1:0]  held_v_ff [2];

   // Only the third corner needs room in the queue.
   assign req_full = (corner_count_ff == LastCorner) && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = accept && (corner_count_ff == LastCorner);

   assign corner_count_in = (corner_count_ff == LastCorner) ? 2'd0 : corner_count_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_count_ff <= 2'd0;
      end else if (accept) begin
         corner_count_ff <= corner_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (corner_count_ff != LastCorner)) begin
         held_x_ff[corner_count_ff[0]] <= req_point_x;
         held_y_ff[corner_count_ff[0]] <= req_point_y;
         held_z_ff[corner_count_ff[0]] <= req_point_z;
         held_u_ff[corner_count_ff[0]] <= req_tex_u;
         held_v_ff[corner_count_ff[0]] <= req_tex_v;
      end
   end

   always_comb begin
      q_data.p10_x = ttb_pkg::PdW'(held_x_ff[1]) - ttb_pkg::PdW'(held_x_ff[0]);
      q_data.p10_y = ttb_pkg::PdW'(held_y_ff[1]) - ttb_pkg::PdW'(held_y_ff[0]);
      q_data.p10_z = ttb_pkg::PdW'(held_z_ff[1]) - ttb_pkg::PdW'(held_z_ff[0]);
      q_data.p20_x = ttb_pkg::PdW'(req_point_x) - ttb_pkg::PdW'(held_x_ff[0]);
      q_data.p20_y = ttb_pkg::PdW'(req_point_y) - ttb_pkg::PdW'(held_y_ff[0]);
      q_data.p20_z = ttb_pkg::PdW'(req_point_z) - ttb_pkg::PdW'(held_z_ff[0]);
      q_data.u10   = ttb_pkg::UdW'(held_u_ff[1]) - ttb_pkg::UdW'(held_u_ff[0]);
      q_data.v10   = ttb_pkg::UdW'(held_v_ff[1]) - ttb_pkg::UdW'(held_v_ff[0]);
      q_data.u20   = ttb_pkg::UdW'(req_tex_u) - ttb_pkg::UdW'(held_u_ff[0]);
      q_data.v20   = ttb_pkg::UdW'(req_tex_v) - ttb_pkg::UdW'(held_v_ff[0]);
   end

endmodule

[rtl/ttb_queue.sv]
// Short queue of triangle records between the corner capture and the arithmetic back end.
module ttb_queue #(
   parameter int DEPTH = ttb_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ttb_pkg::ttb_tri_type data_in,
   output logic                 full,
   input  logic                 pop,
   output ttb_pkg::ttb_tri_type data_out,
   output logic                 empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   ttb_pkg::ttb_tri_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

[rtl/ttb_divider.sv]
// One signed division lane: num * 2^30 / den, truncated toward zero and saturated.
module ttb_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [ttb_pkg::NumW-1:0] num,
   input  logic signed [ttb_pkg::DenW-1:0] den,
   output logic                            done,
   output logic signed [ttb_pkg::OutW-1:0] result,
   output logic                            sat
);

   localparam int Iters = ttb_pkg::QuotW / ttb_pkg::StepsPerCycle;
   localparam int IterW = $clog2(Iters);
   localparam int CmpW  = ttb_pkg::DenW + ttb_pkg::IntBits;
   localparam int QW    = ttb_pkg::QuotW;
   localparam int RW    = ttb_pkg::RemW;

   typedef enum logic [1:0] {L_IDLE, L_RUN, L_FIN} lane_state_type;

   lane_state_type                  state_ff;
   logic [RW-1:0]                   rem_ff;
   logic [QW-1:0]                   feed_ff;
   logic [QW-1:0]                   quot_ff;
   logic [ttb_pkg::NumW-1:0]        nmag_ff;
   logic [ttb_pkg::DenW-1:0]        dmag_ff;
   logic                            neg_ff;
   logic [IterW-1:0]                step_ff;
   logic signed [ttb_pkg::OutW-1:0] result_ff;
   logic                            sat_ff;
   logic                            done_ff;

   logic [ttb_pkg::NumW-1:0] nabs;
   logic [ttb_pkg::DenW-1:0] dabs;
   logic [RW-1:0]            rem_in;
   logic [QW-1:0]            feed_in;
   logic [QW-1:0]            quot_in;
   logic                     ovf;
   logic [QW-1:0]            limit;
   logic [QW-1:0]            mag;
   logic                     clamp;

   assign nabs = num[ttb_pkg::NumW-1] ? ttb_pkg::NumW'(-num) : ttb_pkg::NumW'(num);
   assign dabs = den[ttb_pkg::DenW-1] ? ttb_pkg::DenW'(-den) : ttb_pkg::DenW'(den);

   // Restoring division, a fixed number of quotient bits each cycle.
   always_comb begin
      rem_in  = rem_ff;
      feed_in = feed_ff;
      quot_in = quot_ff;
      for (int s = 0; s < ttb_pkg::StepsPerCycle; s++) begin
         rem_in  = {rem_in[RW-2:0], feed_in[QW-1]};
         feed_in = {feed_in[QW-2:0], 1'b0};
         if (rem_in >= RW'(dmag_ff)) begin
            rem_in  = rem_in - RW'(dmag_ff);
            quot_in = {quot_in[QW-2:0], 1'b1};
         end else begin
            quot_in = {quot_in[QW-2:0], 1'b0};
         end
      end
   end

   // The integer part of the quotient is too wide when num >= den * 2^18.
   assign ovf   = (CmpW'(nmag_ff) >= {dmag_ff, {ttb_pkg::IntBits{1'b0}}});
   assign limit = {1'b0, {(QW - 1){1'b1}}} + QW'(neg_ff);
   assign clamp = ovf || (quot_ff > limit);
   assign mag   = clamp ? limit : quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  state_ff <= L_RUN;
                  done_ff  <= 1'b0;
                  step_ff  <= IterW'(Iters - 1);
                  nmag_ff  <= nabs;
                  dmag_ff  <= dabs;
                  neg_ff   <= (num != '0) && (num[ttb_pkg::NumW-1] != den[ttb_pkg::DenW-1]);
                  rem_ff   <= RW'(nabs >> ttb_pkg::IntBits);
                  feed_ff  <= {nabs[ttb_pkg::IntBits-1:0], {ttb_pkg::FracShift{1'b0}}};
                  quot_ff  <= '0;
               end
            end
            L_RUN: begin
               rem_ff  <= rem_in;
               feed_ff <= feed_in;
               quot_ff <= quot_in;
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= L_FIN;
               end
            end
            L_FIN: begin
               result_ff <= neg_ff ? -$signed(mag) : $signed(mag);
               sat_ff    <= clamp;
               done_ff   <= 1'b1;
               state_ff  <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

[rtl/ttb_back.sv]
// Back end: forms the UV determinant and numerators, runs six division lanes, holds the result.
module ttb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   output logic                            q_pop,
   input  ttb_pkg::ttb_tri_type            q_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_x,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_y,
   output logic signed [ttb_pkg::OutW-1:0] rsp_tangent_z,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_x,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_y,
   output logic signed [ttb_pkg::OutW-1:0] rsp_binormal_z,
   output logic                            rsp_degenerate_uv,
   output logic                            rsp_saturated
);

   localparam int L = ttb_pkg::Lanes;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_START, S_WAIT, S_OUT} back_state_type;

   back_state_type                  state_ff;
   ttb_pkg::ttb_tri_type            rec_ff;
   logic signed [ttb_pkg::DenW-1:0] den_ff;
   logic signed [ttb_pkg::NumW-1:0] tnum_ff [3];
   logic signed [ttb_pkg::NumW-1:0] bnum_ff [3];
   logic                            degen_ff;
   logic signed [ttb_pkg::OutW-1:0] out_vec_ff [L];
   logic                            out_degen_ff;
   logic                            out_sat_ff;
   logic                            out_valid_ff;

   logic signed [ttb_pkg::DenW-1:0] den_in;
   logic signed [ttb_pkg::NumW-1:0] tnum_in [3];
   logic signed [ttb_pkg::NumW-1:0] bnum_in [3];
   logic signed [ttb_pkg::PdW-1:0]  p10 [3];
   logic signed [ttb_pkg::PdW-1:0]  p20 [3];
   logic signed [ttb_pkg::NumW-1:0] lane_num [L];
   logic signed [ttb_pkg::DenW-1:0] lane_den [L];
   logic signed [ttb_pkg::OutW-1:0] lane_result [L];
   logic [L-1:0]                    lane_done;
   logic [L-1:0]                    lane_sat;
   logic                            lane_start;
   logic                            out_free;

   assign p10[0] = rec_ff.p10_x;
   assign p10[1] = rec_ff.p10_y;
   assign p10[2] = rec_ff.p10_z;
   assign p20[0] = rec_ff.p20_x;
   assign p20[1] = rec_ff.p20_y;
   assign p20[2] = rec_ff.p20_z;

   always_comb begin
      den_in = rec_ff.u10 * rec_ff.v20 - rec_ff.v10 * rec_ff.u20;
      for (int k = 0; k < 3; k++) begin
         tnum_in[k] = p10[k] * rec_ff.v20 - p20[k] * rec_ff.v10;
         bnum_in[k] = p10[k] * rec_ff.u20 - p20[k] * rec_ff.u10;
      end
   end

   // The binormal divides by the negated determinant.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_num[k]     = tnum_ff[k];
         lane_num[k + 3] = bnum_ff[k];
         lane_den[k]     = den_ff;
         lane_den[k + 3] = -den_ff;
      end
   end

   assign q_pop      = (state_ff == S_IDLE) && !q_empty;
   assign lane_start = (state_ff == S_START) && (den_ff != '0);
   assign out_free   = !out_valid_ff || rsp_pop;

   for (genvar k = 0; k < L; k++) begin : g_lane
      ttb_divider u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .num    (lane_num[k]),
         .den    (lane_den[k]),
         .done   (lane_done[k]),
         .result (lane_result[k]),
         .sat    (lane_sat[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == S_OUT) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  rec_ff   <= q_data;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               den_ff <= den_in;
               for (int k = 0; k < 3; k++) begin
                  tnum_ff[k] <= tnum_in[k];
                  bnum_ff[k] <= bnum_in[k];
               end
               state_ff <= S_START;
            end
            S_START: begin
               degen_ff <= (den_ff == '0);
               state_ff <= (den_ff == '0) ? S_OUT : S_WAIT;
            end
            S_WAIT: begin
               if (&lane_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  for (int k = 0; k < L; k++) begin
                     out_vec_ff[k] <= degen_ff ? '0 : lane_result[k];
                  end
                  out_degen_ff <= degen_ff;
                  out_sat_ff   <= !degen_ff && (|lane_sat);
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_tangent_x     = out_vec_ff[0];
   assign rsp_tangent_y     = out_vec_ff[1];
   assign rsp_tangent_z     = out_vec_ff[2];
   assign rsp_binormal_x    = out_vec_ff[3];
   assign rsp_binormal_y    = out_vec_ff[4];
   assign rsp_binormal_z    = out_vec_ff[5];
   assign rsp_degenerate_uv = out_degen_ff;
   assign rsp_saturated     = out_sat_ff;

   a_degen_not_sat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_degen_ff) |-> !out_sat_ff)
      else $error("degenerate result also flagged saturated");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_degen_ff) |-> (out_vec_ff[0] == '0 && out_vec_ff[1] == '0 &&
      out_vec_ff[2] == '0 && out_vec_ff[3] == '0 && out_vec_ff[4] == '0 &&
      out_vec_ff[5] == '0))
      else $error("degenerate result carries a nonzero component");

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      lane_start |=> (lane_done == '0))
      else $error("division lane still shows done after start");

   a_pop_to_mul: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_MUL))
      else $error("record taken from queue without entering the multiply step");

endmodule
